/* rtl/core/tfd_pkg.sv */
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and codes of the terminated frame deframer
// Item layouts of both channels, register indexes and request codes.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TERM_VALUE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_RUN   = 1'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Request codes.
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_ABORT = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [7:0] frame_header;
    logic [5:0] frame_length;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;
  } res_item_t;

endpackage

/* rtl/core/terminated_frame_deframer.sv */
// ----------------------------------------------------------------------------
// terminated_frame_deframer: serial byte stream to header plus payload frames
// Collects a header and payload bytes until a run of terminator bytes closes
// the frame, then emits one item per stored byte, or one item if none.
//
// An ordinary byte is taken without a stall. A terminator run broken by a
// non-terminator byte stalls the input while ST_FLUSH writes each held
// terminator, then the breaking byte, as the payload memory has a single
// write port. A closing frame reads each item in ST_READ and loads it into
// the output register in ST_SHOW, which waits while the output stalls; an
// empty frame loads its item in ST_EMPTY. The next byte is taken once the
// last item is registered. The payload memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module terminated_frame_deframer #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  tfd_pkg::req_item_t                req_item,
  output logic                              res_valid,
  input  logic                              res_stall,
  output tfd_pkg::res_item_t                res_item,
  input  logic                              cfg_we,
  input  logic [tfd_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COLLECT,
    PH_TERM
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_READ,
    ST_SHOW,
    ST_EMPTY
  } state_t;

  state_t        state;
  phase_t        phase;
  logic [7:0]    term_value;
  logic [2:0]    term_run;
  logic [2:0]    term_seen;
  logic [7:0]    held_header;
  logic [CW-1:0] count;
  logic [2:0]    flush_left;
  logic [7:0]    held_byte;
  logic [CW-1:0] emit_idx;

  logic [7:0]    payload_store [STORE_DEPTH];
  logic [7:0]    rd_data;

  logic          accept;
  logic          is_term;
  logic [2:0]    need;
  logic [2:0]    term_inc;
  logic          can_store;
  logic          push_en;
  logic [7:0]    push_data;
  logic          mem_we;
  logic          out_free;
  logic [CW-1:0] emit_idx_next;
  logic          emit_last;

  assign req_stall     = (state != ST_IDLE);
  assign accept        = req_valid && !req_stall;
  assign is_term       = (req_item.data_byte == term_value);
  assign need          = (term_run == 3'd0) ? 3'd1 : term_run;
  assign term_inc      = term_seen + 3'd1;
  assign can_store     = (count < CW'(STORE_DEPTH));
  assign out_free      = !res_valid || !res_stall;
  assign emit_idx_next = emit_idx + CW'(1);
  assign emit_last     = (emit_idx_next == count);

  always_comb begin
    push_en   = 1'b0;
    push_data = req_item.data_byte;
    if (state == ST_FLUSH) begin
      push_en   = 1'b1;
      push_data = (flush_left != 3'd0) ? term_value : held_byte;
    end else if (accept && req_item.req_type == tfd_pkg::REQ_DATA &&
                 phase == PH_COLLECT && !is_term) begin
      push_en = 1'b1;
    end
  end

  assign mem_we = push_en && can_store;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_store[count[AW-1:0]] <= push_data;
    end
    rd_data <= payload_store[emit_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_HEADER;
      term_value  <= 8'd255;
      term_run    <= 3'd3;
      term_seen   <= 3'd0;
      held_header <= 8'd0;
      count       <= '0;
      flush_left  <= 3'd0;
      emit_idx    <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tfd_pkg::REG_TERM_VALUE: term_value <= cfg_data[7:0];
          tfd_pkg::REG_TERM_RUN:   term_run   <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (mem_we) begin
        count <= count + CW'(1);
      end

      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_item.req_type == tfd_pkg::REQ_ABORT) begin
              phase     <= PH_HEADER;
              term_seen <= 3'd0;
              count     <= '0;
            end else begin
              unique case (phase)
                PH_COLLECT: begin
                  if (is_term) begin
                    term_seen <= 3'd1;
                    if (need == 3'd1) begin
                      emit_idx <= '0;
                      state    <= (count == '0) ? ST_EMPTY : ST_READ;
                    end else begin
                      phase <= PH_TERM;
                    end
                  end
                end
                PH_TERM: begin
                  if (is_term) begin
                    term_seen <= term_inc;
                    // A run that wraps the counter closes the frame as well.
                    if (term_inc >= need || term_inc == 3'd0) begin
                      emit_idx <= '0;
                      state    <= (count == '0) ? ST_EMPTY : ST_READ;
                    end
                  end else begin
                    flush_left <= term_seen;
                    held_byte  <= req_item.data_byte;
                    phase      <= PH_COLLECT;
                    state      <= ST_FLUSH;
                  end
                end
                default: begin
                  held_header <= req_item.data_byte;
                  count       <= '0;
                  term_seen   <= 3'd0;
                  phase       <= PH_COLLECT;
                end
              endcase
            end
          end
        end

        ST_FLUSH: begin
          // Held terminators go back into the payload first, then the byte
          // that broke the run.
          if (flush_left != 3'd0) begin
            flush_left <= flush_left - 3'd1;
          end else begin
            term_seen <= 3'd0;
            state     <= ST_IDLE;
          end
        end

        ST_READ: begin
          state <= ST_SHOW;
        end

        ST_SHOW: begin
          if (out_free) begin
            res_valid              <= 1'b1;
            res_item.frame_header  <= held_header;
            res_item.frame_length  <= 6'(count);
            res_item.has_byte      <= 1'b1;
            res_item.payload_byte  <= rd_data;
            res_item.byte_index    <= 5'(emit_idx);
            res_item.last          <= emit_last;
            if (emit_last) begin
              phase     <= PH_HEADER;
              term_seen <= 3'd0;
              count     <= '0;
              state     <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx_next;
              state    <= ST_READ;
            end
          end
        end

        ST_EMPTY: begin
          if (out_free) begin
            res_valid              <= 1'b1;
            res_item.frame_header  <= held_header;
            res_item.frame_length  <= 6'd0;
            res_item.has_byte      <= 1'b0;
            res_item.payload_byte  <= 8'd0;
            res_item.byte_index    <= 5'd0;
            res_item.last          <= 1'b1;
            phase                  <= PH_HEADER;
            term_seen              <= 3'd0;
            count                  <= '0;
            state                  <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
